@@ rtl/polygon_area_perimeter_convexity_top_assert.svh @@
// Assertion macros shared by the checker.
`ifndef POLYGON_AREA_PERIMETER_CONVEXITY_TOP_ASSERT_SVH
`define POLYGON_AREA_PERIMETER_CONVEXITY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PAP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pap: same-cycle check failed");

// Next-cycle implication.
`define PAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pap: next-cycle check failed");

`endif

@@ rtl/pap_pkg.sv @@
package pap_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MAX_VERTICES = 256;
	localparam int AREA_BITS    = 40;
	localparam int PERIM_BITS   = 25;
	localparam int QUEUE_DEPTH  = 4;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         last;
	} vtx_t;

	typedef struct packed {
		logic [AREA_BITS-1:0]         double_area;
		logic [PERIM_BITS-1:0]        perimeter;
		logic signed [COORD_BITS-1:0] centroid_x;
		logic signed [COORD_BITS-1:0] centroid_y;
		logic                         convex;
		logic                         degenerate;
		logic                         overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SQRT,
		ST_TRI,
		ST_AFTER,
		ST_FIN,
		ST_DIV,
		ST_OUT
	} back_state_t;

	// closing phase of the polygon
	typedef enum logic [1:0] {
		CL_NONE,
		CL_TRI_A,
		CL_TRI_B
	} close_t;

endpackage

@@ rtl/pap_front.sv @@
module pap_front #(
	parameter int DEPTH = pap_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pap_pkg::vtx_t in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output pap_pkg::vtx_t out_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pap_pkg::vtx_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   fill_q;
	logic            push, pop;

	assign in_ready  = (fill_q != CW'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/pap_div.sv @@
module pap_div #(
	parameter int W  = 25,
	parameter int NW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] dividend,
	input  logic [NW-1:0]       divisor,
	output logic                done,
	output logic signed [W-1:0] quotient
);

	localparam int KW = $clog2(W + 1);

	logic [W-1:0]  mag_q;
	logic [NW:0]   rem_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q, done_q, neg_q;
	logic [NW:0]   rem_sh;
	logic          fits;

	assign rem_sh   = {rem_q[NW-1:0], mag_q[W-1]};
	assign fits     = (rem_sh >= {1'b0, divisor});
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(W);
			neg_q  <= dividend[W-1];
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[W-2:0], fits};
			rem_q <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
		end
	end

endmodule

@@ rtl/pap_back.sv @@
module pap_back #(
	parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_pop,
	input  pap_pkg::vtx_t    in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output pap_pkg::result_t out_res
);

	localparam int CB   = pap_pkg::COORD_BITS;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int DW   = CB + 1;
	localparam int PW   = 2 * DW;
	localparam int ZW   = PW + 1;
	localparam int SW   = CB + CW;
	localparam int AW0  = 2 * CB + CW + 2;
	localparam int AW   = (AW0 > pap_pkg::AREA_BITS + 1) ? AW0 : pap_pkg::AREA_BITS + 1;
	localparam int EB   = pap_pkg::PERIM_BITS;

	pap_pkg::back_state_t state_q, state_d;

	logic signed [CB-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic signed [CB-1:0] prev_x_q, prev_y_q, older_x_q, older_y_q;
	logic signed [CB-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;
	logic signed [CB-1:0] ta_x_q, ta_y_q, tb_x_q, tb_y_q, tc_x_q, tc_y_q;
	logic signed [AW-1:0] area_q;
	logic [EB-1:0]        edge_q;
	logic signed [SW-1:0] sum_x_q, sum_y_q;
	logic [CW-1:0]        cnt_q;
	logic                 fsign_q, mism_q, over_q, last_q, pend_tri_q, tri_first_q;
	pap_pkg::close_t      close_q;
	logic [2:0]           mcnt_q;
	logic signed [PW-1:0] prod_q, prod;
	logic [PW-1:0]        sq_q, rem_q, root_q, bit_q, trial;
	logic signed [ZW-1:0] z_q, zf;
	logic signed [DW-1:0] mul_a, mul_b;
	logic                 out_valid_q, out_free, div_start, div_done_x, div_done_y;
	logic signed [SW-1:0] quo_x, quo_y;
	logic [AW-1:0]        area_mag;
	logic [EB:0]          edge_sum;
	pap_pkg::result_t     res_q, res_d;

	function automatic logic signed [DW-1:0] ext(input logic signed [CB-1:0] v);
		ext = {v[CB-1], v};
	endfunction

	function automatic logic signed [AW-1:0] ext_a(input logic signed [PW-1:0] v);
		ext_a = {{(AW - PW){v[PW-1]}}, v};
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign prod      = mul_a * mul_b;
	assign trial     = root_q + bit_q;
	assign zf        = z_q - {prod_q[PW-1], prod_q};
	assign area_mag  = area_q[AW-1] ? AW'(-area_q) : AW'(area_q);
	assign edge_sum  = {1'b0, edge_q} + (EB + 1)'(root_q);
	assign div_start = (state_q == pap_pkg::ST_FIN) && !over_q && (cnt_q >= CW'(3));

	pap_div #(.W(SW), .NW(CW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_x_q),
		.divisor(cnt_q), .done(div_done_x), .quotient(quo_x)
	);

	pap_div #(.W(SW), .NW(CW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_y_q),
		.divisor(cnt_q), .done(div_done_y), .quotient(quo_y)
	);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pap_pkg::ST_EDGE: begin
				case (mcnt_q)
					3'd0: begin
						mul_a = ext(eb_x_q) - ext(ea_x_q);
						mul_b = mul_a;
					end
					3'd1: begin
						mul_a = ext(eb_y_q) - ext(ea_y_q);
						mul_b = mul_a;
					end
					3'd2: begin
						mul_a = ext(ea_x_q);
						mul_b = ext(eb_y_q);
					end
					default: begin
						mul_a = ext(ea_y_q);
						mul_b = ext(eb_x_q);
					end
				endcase
			end
			pap_pkg::ST_TRI: begin
				if (mcnt_q == 3'd0) begin
					mul_a = ext(tc_x_q) - ext(tb_x_q);
					mul_b = ext(ta_y_q) - ext(tb_y_q);
				end else begin
					mul_a = ext(tc_y_q) - ext(tb_y_q);
					mul_b = ext(ta_x_q) - ext(tb_x_q);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_d = '0;
		if (over_q) begin
			res_d.overflow = 1'b1;
		end else if (cnt_q < CW'(3)) begin
			res_d.degenerate = 1'b1;
		end else begin
			res_d.double_area = (area_mag[AW-1:pap_pkg::AREA_BITS] != '0) ?
				'1 : area_mag[pap_pkg::AREA_BITS-1:0];
			res_d.perimeter   = edge_q;
			res_d.centroid_x  = quo_x[CB-1:0];
			res_d.centroid_y  = quo_y[CB-1:0];
			res_d.convex      = !mism_q;
		end
	end

	always_comb begin
		state_d = state_q;
		in_pop  = 1'b0;
		case (state_q)
			pap_pkg::ST_IDLE: begin
				if (in_valid) begin
					in_pop = 1'b1;
					if (cnt_q >= CW'(MAX_VERTICES) || cnt_q == '0) begin
						state_d = pap_pkg::ST_AFTER;
					end else begin
						state_d = pap_pkg::ST_EDGE;
					end
				end
			end
			pap_pkg::ST_EDGE: begin
				if (mcnt_q == 3'd4) begin
					state_d = pap_pkg::ST_SQRT;
				end
			end
			pap_pkg::ST_SQRT: begin
				if (bit_q == '0) begin
					state_d = pend_tri_q ? pap_pkg::ST_TRI : pap_pkg::ST_AFTER;
				end
			end
			pap_pkg::ST_TRI: begin
				if (mcnt_q == 3'd2) begin
					case (close_q)
						pap_pkg::CL_TRI_A: state_d = pap_pkg::ST_TRI;
						pap_pkg::CL_TRI_B: state_d = pap_pkg::ST_DIV;
						default:           state_d = pap_pkg::ST_AFTER;
					endcase
				end
			end
			pap_pkg::ST_AFTER: begin
				state_d = last_q ? pap_pkg::ST_FIN : pap_pkg::ST_IDLE;
			end
			pap_pkg::ST_FIN: begin
				state_d = div_start ? pap_pkg::ST_EDGE : pap_pkg::ST_OUT;
			end
			pap_pkg::ST_DIV: begin
				if (div_done_x && div_done_y) begin
					state_d = pap_pkg::ST_OUT;
				end
			end
			pap_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = pap_pkg::ST_IDLE;
				end
			end
			default: state_d = pap_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q   <= '0;
			first_y_q   <= '0;
			second_x_q  <= '0;
			second_y_q  <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			older_x_q   <= '0;
			older_y_q   <= '0;
			area_q      <= '0;
			edge_q      <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			cnt_q       <= '0;
			fsign_q     <= 1'b0;
			mism_q      <= 1'b0;
			over_q      <= 1'b0;
			last_q      <= 1'b0;
			pend_tri_q  <= 1'b0;
			tri_first_q <= 1'b0;
			close_q     <= pap_pkg::CL_NONE;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			ea_x_q      <= '0;
			ea_y_q      <= '0;
			eb_x_q      <= '0;
			eb_y_q      <= '0;
			ta_x_q      <= '0;
			ta_y_q      <= '0;
			tb_x_q      <= '0;
			tb_y_q      <= '0;
			tc_x_q      <= '0;
			tc_y_q      <= '0;
			sq_q        <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			bit_q       <= '0;
			z_q         <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != pap_pkg::ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pap_pkg::ST_IDLE: begin
					if (in_valid) begin
						last_q <= in_item.last;
						mcnt_q <= '0;
						if (cnt_q >= CW'(MAX_VERTICES)) begin
							over_q <= 1'b1;
						end else begin
							if (cnt_q == '0) begin
								first_x_q <= in_item.x;
								first_y_q <= in_item.y;
							end
							if (cnt_q == CW'(1)) begin
								second_x_q <= in_item.x;
								second_y_q <= in_item.y;
							end
							ea_x_q      <= prev_x_q;
							ea_y_q      <= prev_y_q;
							eb_x_q      <= in_item.x;
							eb_y_q      <= in_item.y;
							ta_x_q      <= older_x_q;
							ta_y_q      <= older_y_q;
							tb_x_q      <= prev_x_q;
							tb_y_q      <= prev_y_q;
							tc_x_q      <= in_item.x;
							tc_y_q      <= in_item.y;
							pend_tri_q  <= (cnt_q >= CW'(2));
							tri_first_q <= (cnt_q == CW'(2));
							sum_x_q     <= sum_x_q + SW'(in_item.x);
							sum_y_q     <= sum_y_q + SW'(in_item.y);
							older_x_q   <= prev_x_q;
							older_y_q   <= prev_y_q;
							prev_x_q    <= in_item.x;
							prev_y_q    <= in_item.y;
							cnt_q       <= cnt_q + 1'b1;
						end
					end
				end
				pap_pkg::ST_EDGE: begin
					mcnt_q <= (mcnt_q == 3'd4) ? '0 : mcnt_q + 1'b1;
					case (mcnt_q)
						3'd1: sq_q   <= prod_q;
						3'd2: sq_q   <= sq_q + prod_q;
						3'd3: area_q <= area_q + ext_a(prod_q);
						3'd4: begin
							area_q <= area_q - ext_a(prod_q);
							rem_q  <= sq_q;
							root_q <= '0;
							bit_q  <= PW'(1) << (2 * CB);
						end
						default: ;
					endcase
				end
				pap_pkg::ST_SQRT: begin
					if (bit_q == '0) begin
						edge_q <= edge_sum[EB] ? '1 : edge_sum[EB-1:0];
					end else begin
						if (rem_q >= trial) begin
							rem_q  <= rem_q - trial;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				pap_pkg::ST_TRI: begin
					mcnt_q <= (mcnt_q == 3'd2) ? '0 : mcnt_q + 1'b1;
					if (mcnt_q == 3'd1) begin
						z_q <= {prod_q[PW-1], prod_q};
					end else if (mcnt_q == 3'd2) begin
						if (tri_first_q) begin
							fsign_q <= (zf > 0);
						end else if ((zf > 0) != fsign_q) begin
							mism_q <= 1'b1;
						end
						if (close_q == pap_pkg::CL_TRI_A) begin
							// wrap-around triple: last, first, second
							ta_x_q  <= prev_x_q;
							ta_y_q  <= prev_y_q;
							tb_x_q  <= first_x_q;
							tb_y_q  <= first_y_q;
							tc_x_q  <= second_x_q;
							tc_y_q  <= second_y_q;
							close_q <= pap_pkg::CL_TRI_B;
						end
					end
				end
				pap_pkg::ST_FIN: begin
					mcnt_q <= '0;
					if (div_start) begin
						ea_x_q      <= prev_x_q;
						ea_y_q      <= prev_y_q;
						eb_x_q      <= first_x_q;
						eb_y_q      <= first_y_q;
						ta_x_q      <= older_x_q;
						ta_y_q      <= older_y_q;
						tb_x_q      <= prev_x_q;
						tb_y_q      <= prev_y_q;
						tc_x_q      <= first_x_q;
						tc_y_q      <= first_y_q;
						pend_tri_q  <= 1'b1;
						tri_first_q <= 1'b0;
						close_q     <= pap_pkg::CL_TRI_A;
					end
				end
				pap_pkg::ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q       <= res_d;
						first_x_q   <= '0;
						first_y_q   <= '0;
						second_x_q  <= '0;
						second_y_q  <= '0;
						prev_x_q    <= '0;
						prev_y_q    <= '0;
						older_x_q   <= '0;
						older_y_q   <= '0;
						area_q      <= '0;
						edge_q      <= '0;
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						cnt_q       <= '0;
						fsign_q     <= 1'b0;
						mism_q      <= 1'b0;
						over_q      <= 1'b0;
						last_q      <= 1'b0;
						pend_tri_q  <= 1'b0;
						close_q     <= pap_pkg::CL_NONE;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/polygon_area_perimeter_convexity_top.sv @@
// channel | dir | tdata (low bit up)                              | tuser / tlast
// s_      | in  | vertex_x[15:0], vertex_y[31:16]                 | tlast = last_vertex
// m_      | out | double_area, perimeter, centroid_x/y, convex    | degenerate, overflow
//
// Vertices queue up in a small FIFO; the back end takes one at a time.
// The first vertex is only stored; each later one runs an edge step on the shared
// multiplier and the edge square root, and from the third on also a cross product.
// With three or more vertices the last one then adds a closing edge and two cross
// products while the centroid dividers run alongside. Asynchronous active-low reset
// clears control and accumulator state, not FIFO storage; a stalled result holds in
// the output register while the back end waits, and the input keeps filling the FIFO.
module polygon_area_perimeter_convexity_top #(
	parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // vertex_x[15:0], vertex_y[31:16]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// double_area[39:0], perimeter[64:40], centroid_x[80:65], centroid_y[96:81],
	// convex[97], zero fill
	output logic [103:0] m_tdata,
	output logic [1:0]   m_tuser   // degenerate[0], overflow[1]
);

	pap_pkg::vtx_t    in_item, q_item;
	pap_pkg::result_t res;
	logic             q_valid, q_pop;

	assign in_item.x    = s_tdata[15:0];
	assign in_item.y    = s_tdata[31:16];
	assign in_item.last = s_tlast;

	pap_front #(.DEPTH(pap_pkg::QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
		.out_valid(q_valid), .out_ready(q_pop), .out_item(q_item)
	);

	pap_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_pop(q_pop), .in_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {6'b0, res.convex, res.centroid_y, res.centroid_x,
		res.perimeter, res.double_area};
	assign m_tuser = {res.overflow, res.degenerate};

endmodule

@@ rtl/pap_checker.sv @@
`include "polygon_area_perimeter_convexity_top_assert.svh"

module pap_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [1:0]   m_tuser
);

	`PAP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`PAP_ASSERT_NOW(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]))
	`PAP_ASSERT_NOW(a_flag_zero, m_tvalid && (m_tuser[0] || m_tuser[1]), m_tdata == '0)

endmodule

bind polygon_area_perimeter_convexity_top pap_checker u_pap_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ test/tb.sv @@
module tb;

	localparam int MAX_VERTICES   = pap_pkg::MAX_VERTICES;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM       = 450;

	typedef struct {
		logic [39:0] double_area;
		logic [24:0] perimeter;
		logic [15:0] centroid_x;
		logic [15:0] centroid_y;
		logic        convex;
		logic        degenerate;
		logic        overflow;
	} poly_result_t;

	// Polygon measurement predictor and store of pending results
	class polygon_scoreboard;
		longint fx, fy, sx, sy, px, py, ox, oy;
		longint area_acc, sumx, sumy;
		longint unsigned edge_acc;
		int unsigned count;
		bit first_pos, mismatch, over;
		poly_result_t pending[$];
		int errors;
		int results_seen;

		function void clear_polygon();
			fx = 0; fy = 0; sx = 0; sy = 0; px = 0; py = 0; ox = 0; oy = 0;
			area_acc = 0; sumx = 0; sumy = 0; edge_acc = 0;
			count = 0; first_pos = 0; mismatch = 0; over = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function void add_edge(longint ax, longint ay, longint bx, longint by);
			longint dx, dy;
			dx = bx - ax;
			dy = by - ay;
			area_acc += ax * by - ay * bx;
			edge_acc += int_sqrt(dx * dx + dy * dy);
			if (edge_acc > 64'h1FF_FFFF) edge_acc = 64'h1FF_FFFF;
		endfunction

		function void turn(longint ax, longint ay, longint bx, longint by,
				longint cx, longint cy, bit is_first);
			longint z;
			z = (cx - bx) * (ay - by) - (cy - by) * (ax - bx);
			if (is_first) first_pos = z > 0;
			else if ((z > 0) != first_pos) mismatch = 1;
		endfunction

		function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy, bit last);
			longint x, y, n, mag, cx, cy;
			poly_result_t r;
			x = vx;
			y = vy;
			if (count >= MAX_VERTICES) over = 1;
			else begin
				if (count == 0) begin
					fx = x; fy = y;
				end else begin
					if (count == 1) begin
						sx = x; sy = y;
					end
					add_edge(px, py, x, y);
					if (count >= 2) turn(ox, oy, px, py, x, y, count == 2);
				end
				sumx += x; sumy += y;
				ox = px; oy = py; px = x; py = y;
				count++;
			end
			if (!last) return;
			r = '{default: 0};
			if (over) r.overflow = 1;
			else if (count < 3) r.degenerate = 1;
			else begin
				n = count;
				add_edge(px, py, fx, fy);
				turn(ox, oy, px, py, fx, fy, 0);
				turn(px, py, fx, fy, sx, sy, 0);
				mag = area_acc < 0 ? -area_acc : area_acc;
				if (mag > 64'hFF_FFFF_FFFF) mag = 64'hFF_FFFF_FFFF;
				cx = sumx / n;
				cy = sumy / n;
				r.double_area = mag[39:0];
				r.perimeter   = edge_acc[24:0];
				r.centroid_x  = cx[15:0];
				r.centroid_y  = cy[15:0];
				r.convex      = !mismatch;
			end
			pending.push_back(r);
			clear_polygon();
		endfunction

		function void check_result(logic [103:0] d, logic [1:0] u);
			poly_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction: %h %b", d, u);
				return;
			end
			e = pending.pop_front();
			if (d[39:0] !== e.double_area || d[64:40] !== e.perimeter ||
					d[80:65] !== e.centroid_x || d[96:81] !== e.centroid_y ||
					d[97] !== e.convex || d[103:98] !== 6'd0 ||
					u[0] !== e.degenerate || u[1] !== e.overflow) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp area %h per %h cx %h cy %h cvx %b dg %b ov %b",
						e.double_area, e.perimeter, e.centroid_x, e.centroid_y,
						e.convex, e.degenerate, e.overflow, " | got %h %b", d, u);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [31:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [103:0] m_tdata;
	logic [1:0] m_tuser;

	polygon_scoreboard sb;
	int idle_cycles = 0;
	int polygons;
	bit timed_out;

	polygon_area_perimeter_convexity_top uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver stall pattern: phases of always-ready and of random stalls
	initial begin
		int phase;
		m_tready = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if ((phase / 300) % 3 == 0) m_tready <= 1;
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog expired, %0d results outstanding", sb.pending.size());
		$display("** polygon_area_perimeter_convexity_top: FAILED **");
		$finish;
	end

	int burst_left;

	task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_vertex(x, y, last);
		burst_left--;
	endtask

	task automatic send_polygon(int n, int span);
		logic signed [15:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = 16'($signed($urandom_range(0, 2 * span)) - span);
			y = 16'($signed($urandom_range(0, 2 * span)) - span);
			if ($urandom_range(0, 15) == 0) x = 16'($urandom);
			if ($urandom_range(0, 15) == 0) y = 16'($urandom);
			send_vertex(x, y, i == n - 1);
		end
		polygons++;
	endtask

	// regular n-gon scaled by r, convex in either direction
	task automatic send_regular(int n, int r, bit reverse);
		real a;
		for (int i = 0; i < n; i++) begin
			a = 6.2831853 * (reverse ? n - i : i) / n;
			send_vertex(16'($rtoi(r * $cos(a))), 16'($rtoi(r * $sin(a))), i == n - 1);
		end
		polygons++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int sent_before;
		sb = new();
		sb.clear_polygon();
		sb.errors = 0;
		sb.results_seen = 0;
		polygons = 0;
		burst_left = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: small and degenerate polygons, extremes, collinear, concave
		send_vertex(16'sh7fff, 16'sh8000, 1);
		send_vertex(0, 0, 0); send_vertex(5, 5, 1);
		send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
		send_vertex(32767, 32767, 0); send_vertex(-32768, 32767, 1);
		send_vertex(0, 0, 0); send_vertex(16, 16, 0); send_vertex(32, 32, 1);
		send_vertex(0, 0, 0); send_vertex(100, 0, 0);
		send_vertex(20, 20, 0); send_vertex(0, 100, 1);
		drain();
		send_regular(5, 20000, 0);
		send_regular(6, 30000, 1);
		// overflow: one past the vertex limit, then exactly at the limit, then five past it
		send_polygon(MAX_VERTICES + 1, 32767);
		send_regular(MAX_VERTICES, 32000, 0);
		send_polygon(MAX_VERTICES + 5, 1000);
		// the sender holds off until every result has come back
		drain();

		sent_before = 0;
		while (sent_before < N_RANDOM) begin
			int n, kind;
			kind = $urandom_range(0, 9);
			if (kind < 5) n = $urandom_range(3, 8);
			else if (kind < 7) n = $urandom_range(1, 2);
			else if (kind < 9) n = $urandom_range(9, 40);
			else n = $urandom_range(100, MAX_VERTICES + 3);
			if ($urandom_range(0, 3) == 0) send_regular((n < 3) ? 3 : n,
					$urandom_range(10, 32000), 1'($urandom_range(0, 1)));
			else send_polygon(n, (kind == 1) ? 32767 : $urandom_range(1, 32767));
			sent_before += n;
			if ($urandom_range(0, 40) == 0) drain();
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d polygons with %0d results, incl. degenerate, overflow, concave",
			polygons, sb.results_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** polygon_area_perimeter_convexity_top: PASSED **");
		else
			$display("** polygon_area_perimeter_convexity_top: FAILED **");
		$finish;
	end
endmodule

@@ polygon_area_perimeter_convexity_top.f @@
+incdir+rtl
rtl/pap_pkg.sv
rtl/pap_front.sv
rtl/pap_div.sv
rtl/pap_back.sv
rtl/polygon_area_perimeter_convexity_top.sv
rtl/pap_checker.sv
test/tb.sv
